@@ src/bmh_pkg.sv @@
`default_nettype none
package bmh_pkg;

	localparam int HEAP_DEPTH = 16;
	localparam int IDX_W      = $clog2(HEAP_DEPTH);
	localparam int CNT_W      = IDX_W + 1;
	localparam int CHILD_W    = IDX_W + 2;
	localparam int KEY_W      = 32;

	localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
	localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};

	typedef enum logic [1:0] {
		CMD_INSERT   = 2'd0,
		CMD_EXTRACT  = 2'd1,
		CMD_DECREASE = 2'd2,
		CMD_DELETE   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_FULL        = 3'd1,
		ST_EMPTY       = 3'd2,
		ST_RANGE       = 3'd3,
		ST_NOT_SMALLER = 3'd4
	} status_t;

	typedef struct packed {
		cmd_t                    command;
		logic signed [KEY_W-1:0] key;
		logic [IDX_W-1:0]        index;
	} heap_in_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] removed_key;
		logic signed [KEY_W-1:0] min_key;
		logic [CNT_W-1:0]        entry_count;
		status_t                 status;
	} heap_out_t;

	typedef enum logic [3:0] {
		OP_NONE    = 4'd0,
		OP_LOAD    = 4'd1,
		OP_FAIL    = 4'd2,
		OP_INS     = 4'd3,
		OP_TAKE    = 4'd4,
		OP_EXT     = 4'd5,
		OP_IDX_RD  = 4'd6,
		OP_IDX_CHK = 4'd7,
		OP_UP_RD   = 4'd8,
		OP_UP_CMP  = 4'd9,
		OP_LAST_RD = 4'd10,
		OP_LAST_LD = 4'd11,
		OP_DN_RD   = 4'd12,
		OP_DN_CMP  = 4'd13
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} bmh_ctl_t;

	typedef struct packed {
		cmd_t    cmd;
		status_t chk;
		logic    at_root;
		logic    up_move;
		logic    dn_move;
		logic    not_smaller;
		logic    cnt_zero;
	} bmh_stat_t;

endpackage
`default_nettype wire

@@ src/bmh_ram.sv @@
`default_nettype none
module bmh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [$clog2(DEPTH)-1:0]   waddr,
	input  wire logic [WIDTH-1:0]           wdata,
	input  wire logic [$clog2(DEPTH)-1:0]   raddr_a,
	output logic      [WIDTH-1:0]           rdata_a,
	input  wire logic [$clog2(DEPTH)-1:0]   raddr_b,
	output logic      [WIDTH-1:0]           rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule
`default_nettype wire

@@ src/bmh_dp.sv @@
`default_nettype none
module bmh_dp import bmh_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire bmh_ctl_t  ctl,
	input  wire heap_in_t  item,
	output bmh_stat_t      stat,
	output heap_out_t      result
);

	cmd_t                    cmd_q;
	logic signed [KEY_W-1:0] key_q;
	logic [IDX_W-1:0]        idx_q;
	logic [IDX_W-1:0]        pos_q;
	logic [CNT_W-1:0]        cnt_q;
	logic signed [KEY_W-1:0] root_q;
	logic signed [KEY_W-1:0] removed_q;
	status_t                 status_q;

	logic [IDX_W-1:0]        pos_m1;
	logic [IDX_W-1:0]        parent;
	logic [CHILD_W-1:0]      left_w;
	logic [CHILD_W-1:0]      right_w;
	logic [CHILD_W-1:0]      cnt_w;
	logic signed [KEY_W-1:0] rd_a;
	logic signed [KEY_W-1:0] rd_b;
	logic [KEY_W-1:0]        rdata_a;
	logic [KEY_W-1:0]        rdata_b;
	logic                    l_ok;
	logic                    r_ok;
	logic signed [KEY_W-1:0] l_val;
	logic signed [KEY_W-1:0] best_val;
	logic [IDX_W-1:0]        best_idx;
	logic                    up_move;
	logic                    dn_move;
	status_t                 chk;

	logic                    we;
	logic [IDX_W-1:0]        waddr;
	logic signed [KEY_W-1:0] wdata;
	logic [IDX_W-1:0]        raddr_a;

	assign pos_m1  = pos_q - 1'b1;
	assign parent  = pos_m1 >> 1;
	assign left_w  = {1'b0, pos_q, 1'b1};
	assign right_w = left_w + 1'b1;
	assign cnt_w   = {1'b0, cnt_q};
	assign rd_a    = rdata_a;
	assign rd_b    = rdata_b;

	assign up_move  = rd_a > key_q;
	assign l_ok     = (left_w < cnt_w) && (rd_a < key_q);
	assign l_val    = l_ok ? rd_a : key_q;
	assign r_ok     = (right_w < cnt_w) && (rd_b < l_val);
	assign dn_move  = l_ok | r_ok;
	assign best_val = r_ok ? rd_b : rd_a;
	assign best_idx = r_ok ? right_w[IDX_W-1:0] : left_w[IDX_W-1:0];

	always_comb begin
		chk = ST_OK;
		unique case (cmd_q)
			CMD_INSERT:  if (cnt_q == CNT_W'(HEAP_DEPTH)) chk = ST_FULL;
			CMD_EXTRACT: if (cnt_q == '0) chk = ST_EMPTY;
			default:     if ({1'b0, idx_q} >= cnt_q) chk = ST_RANGE;
		endcase
	end

	always_comb begin
		raddr_a = pos_q;
		we      = 1'b0;
		waddr   = pos_q;
		wdata   = key_q;
		unique case (ctl.op)
			OP_UP_RD: begin
				raddr_a = parent;
				we      = (pos_q == '0);
			end
			OP_UP_CMP: begin
				we    = 1'b1;
				wdata = up_move ? rd_a : key_q;
			end
			OP_LAST_RD: raddr_a = cnt_q[IDX_W-1:0];
			OP_DN_RD:   raddr_a = left_w[IDX_W-1:0];
			OP_DN_CMP: begin
				we    = 1'b1;
				wdata = dn_move ? best_val : key_q;
			end
			default: begin
			end
		endcase
	end

	bmh_ram #(
		.WIDTH (KEY_W),
		.DEPTH (HEAP_DEPTH)
	) u_store (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.rdata_a (rdata_a),
		.raddr_b (right_w[IDX_W-1:0]),
		.rdata_b (rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			unique case (ctl.op)
				OP_INS:           cnt_q <= cnt_q + 1'b1;
				OP_TAKE, OP_EXT:  cnt_q <= cnt_q - 1'b1;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (we && waddr == '0) begin
			root_q <= wdata;
		end
		unique case (ctl.op)
			OP_LOAD: begin
				cmd_q     <= item.command;
				key_q     <= item.key;
				idx_q     <= item.index;
				pos_q     <= item.index;
				removed_q <= KEY_MAX;
				status_q  <= ST_OK;
			end
			OP_FAIL: status_q <= chk;
			OP_INS:  pos_q <= cnt_q[IDX_W-1:0];
			OP_TAKE: begin
				removed_q <= root_q;
				pos_q     <= '0;
			end
			OP_EXT: pos_q <= '0;
			OP_IDX_CHK: begin
				if (cmd_q == CMD_DELETE) begin
					removed_q <= rd_a;
					key_q     <= KEY_MIN;
				end else if (key_q > rd_a) begin
					status_q <= ST_NOT_SMALLER;
				end
			end
			OP_UP_CMP: if (up_move) pos_q <= parent;
			OP_LAST_LD: key_q <= rd_a;
			OP_DN_CMP: if (dn_move) pos_q <= best_idx;
			default: begin
			end
		endcase
	end

	assign stat.cmd         = cmd_q;
	assign stat.chk         = chk;
	assign stat.at_root     = (pos_q == '0);
	assign stat.up_move     = up_move;
	assign stat.dn_move     = dn_move;
	assign stat.not_smaller = key_q > rd_a;
	assign stat.cnt_zero    = (cnt_q == '0);

	assign result.removed_key = removed_q;
	assign result.min_key     = (cnt_q != '0) ? root_q : KEY_MAX;
	assign result.entry_count = cnt_q;
	assign result.status      = status_q;

endmodule
`default_nettype wire

@@ src/bmh_ctrl.sv @@
`default_nettype none
module bmh_ctrl import bmh_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire bmh_stat_t stat,
	output bmh_ctl_t       ctl,
	output logic           busy,
	output logic           done
);

	typedef enum logic [11:0] {
		S_IDLE    = 12'b000000000001,
		S_CHECK   = 12'b000000000010,
		S_IDX_RD  = 12'b000000000100,
		S_IDX_CHK = 12'b000000001000,
		S_UP_RD   = 12'b000000010000,
		S_UP_CMP  = 12'b000000100000,
		S_EXT     = 12'b000001000000,
		S_LAST_RD = 12'b000010000000,
		S_LAST_LD = 12'b000100000000,
		S_DN_RD   = 12'b001000000000,
		S_DN_CMP  = 12'b010000000000,
		S_DONE    = 12'b100000000000
	} state_t;

	state_t state_q;
	state_t state_d;
	state_t up_exit;

	assign up_exit = (stat.cmd == CMD_DELETE) ? S_EXT : S_DONE;

	always_comb begin
		state_d = state_q;
		ctl.op  = OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.op  = OP_LOAD;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.chk != ST_OK) begin
					ctl.op  = OP_FAIL;
					state_d = S_DONE;
				end else begin
					unique case (stat.cmd)
						CMD_INSERT: begin
							ctl.op  = OP_INS;
							state_d = S_UP_RD;
						end
						CMD_EXTRACT: begin
							ctl.op  = OP_TAKE;
							state_d = S_LAST_RD;
						end
						default: state_d = S_IDX_RD;
					endcase
				end
			end
			S_IDX_RD: begin
				ctl.op  = OP_IDX_RD;
				state_d = S_IDX_CHK;
			end
			S_IDX_CHK: begin
				ctl.op  = OP_IDX_CHK;
				state_d = (stat.cmd == CMD_DECREASE && stat.not_smaller) ? S_DONE : S_UP_RD;
			end
			S_UP_RD: begin
				ctl.op  = OP_UP_RD;
				state_d = stat.at_root ? up_exit : S_UP_CMP;
			end
			S_UP_CMP: begin
				ctl.op  = OP_UP_CMP;
				state_d = stat.up_move ? S_UP_RD : up_exit;
			end
			S_EXT: begin
				ctl.op  = OP_EXT;
				state_d = S_LAST_RD;
			end
			S_LAST_RD: begin
				ctl.op  = OP_LAST_RD;
				state_d = stat.cnt_zero ? S_DONE : S_LAST_LD;
			end
			S_LAST_LD: begin
				ctl.op  = OP_LAST_LD;
				state_d = S_DN_RD;
			end
			S_DN_RD: begin
				ctl.op  = OP_DN_RD;
				state_d = S_DN_CMP;
			end
			S_DN_CMP: begin
				ctl.op  = OP_DN_CMP;
				state_d = stat.dn_move ? S_DN_RD : S_DONE;
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

endmodule
`default_nettype wire

@@ src/binary_min_heap_unit.sv @@
// A rejected command goes from accept through the check state straight to done;
// each heap level a sift walks takes one store read, then a compare and write.
// Throughput: one command at a time; start is taken again the cycle after done.
// The single-write, registered-read key store sets the per-level cost.
// Reset (arst_n low) empties the heap at once; the store itself is not cleared.
// The result beat is shown for one cycle with done; the receiver cannot stall it.
`default_nettype none
module binary_min_heap_unit import bmh_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	input  wire heap_in_t item,
	output logic          done,
	output heap_out_t     result
);

	bmh_ctl_t  ctl;
	bmh_stat_t stat;

	bmh_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	bmh_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.item   (item),
		.stat   (stat),
		.result (result)
	);

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted command did not make the unit busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one beat");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == ST_FULL |-> result.entry_count == CNT_W'(HEAP_DEPTH))
		else $error("full status with a heap that is not full");

	a_empty_min: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.entry_count == '0 |-> result.min_key == KEY_MAX)
		else $error("empty heap reports a minimum");
`endif

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
	import bmh_pkg::*;

	typedef struct {
		heap_in_t  stim;
		bit        typed;
		heap_out_t want;
	} dir_row_t;

	localparam int RAND_PER_PHASE = 457;
	localparam int DRAIN_CYCLES   = 40;

	logic      clk;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	logic      busy;
	heap_in_t  item = '0;
	logic      done;
	heap_out_t result;

	logic signed [KEY_W-1:0] heap_keys [HEAP_DEPTH];
	bit                      key_written [HEAP_DEPTH];
	int                      heap_held = 0;
	bit                      filling = 1'b1;

	heap_out_t pending_results [$];
	dir_row_t  dir_rows [$];
	bit        typed_armed = 1'b0;
	heap_out_t typed_want;
	int        mismatch_count = 0;

	binary_min_heap_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic void heap_rise(int i);
		logic signed [KEY_W-1:0] t;
		int p;
		while (i != 0 && heap_keys[(i - 1) / 2] > heap_keys[i]) begin
			p = (i - 1) / 2;
			t = heap_keys[p];
			heap_keys[p] = heap_keys[i];
			heap_keys[i] = t;
			i = p;
		end
	endfunction

	function automatic logic signed [KEY_W-1:0] heap_pop_root();
		logic signed [KEY_W-1:0] root;
		logic signed [KEY_W-1:0] t;
		int i;
		int l;
		int r;
		int b;
		root = heap_keys[0];
		heap_keys[0] = heap_keys[heap_held - 1];
		heap_held--;
		i = 0;
		forever begin
			l = 2 * i + 1;
			r = 2 * i + 2;
			b = i;
			if (l < heap_held && heap_keys[l] < heap_keys[b])
				b = l;
			if (r < heap_held && heap_keys[r] < heap_keys[b])
				b = r;
			if (b == i)
				break;
			t = heap_keys[i];
			heap_keys[i] = heap_keys[b];
			heap_keys[b] = t;
			i = b;
		end
		return root;
	endfunction

	function automatic heap_out_t heap_apply(heap_in_t it);
		heap_out_t r;
		r.removed_key = KEY_MAX;
		r.status = ST_OK;
		case (it.command)
			CMD_INSERT: begin
				if (heap_held >= HEAP_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					heap_keys[heap_held] = it.key;
					key_written[heap_held] = 1'b1;
					heap_held++;
					heap_rise(heap_held - 1);
				end
			end
			CMD_EXTRACT: begin
				if (heap_held == 0)
					r.status = ST_EMPTY;
				else
					r.removed_key = heap_pop_root();
			end
			default: begin
				if (int'(it.index) >= heap_held) begin
					r.status = ST_RANGE;
				end else if (it.command == CMD_DECREASE) begin
					if (it.key > heap_keys[it.index]) begin
						r.status = ST_NOT_SMALLER;
					end else begin
						heap_keys[it.index] = it.key;
						heap_rise(it.index);
					end
				end else begin
					r.removed_key = heap_keys[it.index];
					heap_keys[it.index] = KEY_MIN;
					heap_rise(it.index);
					void'(heap_pop_root());
				end
			end
		endcase
		r.min_key = (heap_held != 0) ? heap_keys[0] : KEY_MAX;
		r.entry_count = heap_held[CNT_W-1:0];
		return r;
	endfunction

	function automatic heap_in_t mk_in(cmd_t c, logic signed [KEY_W-1:0] k,
			logic [IDX_W-1:0] i);
		heap_in_t r;
		r.command = c;
		r.key = k;
		r.index = i;
		return r;
	endfunction

	function automatic heap_out_t mk_out(logic signed [KEY_W-1:0] rk,
			logic signed [KEY_W-1:0] mk, logic [CNT_W-1:0] n, status_t s);
		heap_out_t r;
		r.removed_key = rk;
		r.min_key = mk;
		r.entry_count = n;
		r.status = s;
		return r;
	endfunction

	task automatic add_row(input heap_in_t s, input bit ty, input heap_out_t w);
		dir_row_t r;
		r.stim = s;
		r.typed = ty;
		r.want = w;
		dir_rows.push_back(r);
	endtask

	function automatic logic signed [KEY_W-1:0] rand_key();
		case ($urandom_range(0, 9))
			0: return KEY_MAX;
			1: return KEY_MIN;
			2, 3, 4: return $signed(KEY_W'($urandom_range(0, 40))) - 20;
			default: return $signed(KEY_W'($urandom));
		endcase
	endfunction

	function automatic heap_in_t gen_command();
		heap_in_t it;
		logic signed [KEY_W-1:0] cur;
		longint dv;
		int w;
		if (heap_held == HEAP_DEPTH && $urandom_range(0, 3) == 0)
			filling = 1'b0;
		else if (heap_held == 0)
			filling = 1'b1;
		else if ($urandom_range(0, 59) == 0)
			filling = ~filling;
		if ($urandom_range(0, 19) == 0) begin
			it.command = cmd_t'($urandom_range(0, 3));
			it.key = $signed(KEY_W'($urandom));
			it.index = IDX_W'($urandom_range(0, HEAP_DEPTH - 1));
		end else begin
			w = $urandom_range(0, 99);
			if (filling)
				it.command = (w < 55) ? CMD_INSERT : (w < 70) ? CMD_EXTRACT :
					(w < 85) ? CMD_DECREASE : CMD_DELETE;
			else
				it.command = (w < 15) ? CMD_INSERT : (w < 55) ? CMD_EXTRACT :
					(w < 70) ? CMD_DECREASE : CMD_DELETE;
			if (heap_held > 0 && $urandom_range(0, 9) < 8)
				it.index = IDX_W'($urandom_range(0, heap_held - 1));
			else
				it.index = IDX_W'($urandom_range(0, HEAP_DEPTH - 1));
			it.key = rand_key();
			if (it.command == CMD_DECREASE && int'(it.index) < heap_held) begin
				cur = heap_keys[it.index];
				case ($urandom_range(0, 9))
					0: dv = longint'(cur);
					1: dv = longint'(rand_key());
					2, 3: dv = longint'(cur) - $urandom_range(1, 3);
					4: dv = longint'(cur) - longint'($urandom);
					default: dv = longint'(cur) - $urandom_range(0, 32'h00FF_FFFF);
				endcase
				it.key = (dv < longint'(KEY_MIN)) ? KEY_MIN : dv[KEY_W-1:0];
			end
		end
		if ((it.command == CMD_DECREASE || it.command == CMD_DELETE) &&
				!key_written[it.index])
			it.command = CMD_INSERT;
		return it;
	endfunction

	task automatic drive_item(input heap_in_t it, input int idle_pct,
			input bit ty, input heap_out_t w);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		typed_armed = ty;
		typed_want = w;
		start <= 1'b1;
		item <= it;
		do
			@(posedge clk);
		while (!(start && !busy));
	endtask

	task automatic wait_idle();
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		heap_out_t want;
		if (arst_n) begin
			if (done) begin
				if (pending_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result beat: removed=%0d min=%0d count=%0d status=%0d",
							result.removed_key, result.min_key, result.entry_count,
							result.status);
				end else begin
					want = pending_results.pop_front();
					if (result.removed_key !== want.removed_key ||
							result.min_key !== want.min_key ||
							result.entry_count !== want.entry_count ||
							result.status !== want.status) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("mismatch: exp removed=%0d min=%0d count=%0d status=%0d, got removed=%0d min=%0d count=%0d status=%0d",
								want.removed_key, want.min_key, want.entry_count,
								want.status, result.removed_key, result.min_key,
								result.entry_count, result.status);
					end
				end
			end
			if (start && !busy) begin
				want = heap_apply(item);
				if (typed_armed) begin
					want = typed_want;
					typed_armed = 1'b0;
				end
				pending_results.push_back(want);
			end
		end
	end

	initial begin
		heap_in_t it;
		heap_out_t none;
		int ph;
		int n;
		int pct;
		none = '0;
		for (n = 0; n < HEAP_DEPTH; n++)
			key_written[n] = 1'b0;

		add_row(mk_in(CMD_EXTRACT, 32'sd0, 4'hF), 1'b1,
			mk_out(KEY_MAX, KEY_MAX, 5'd0, ST_EMPTY));
		add_row(mk_in(CMD_INSERT, KEY_MAX, 4'hF), 1'b0, none);
		add_row(mk_in(CMD_INSERT, 32'sd0, 4'h0), 1'b0, none);
		add_row(mk_in(CMD_INSERT, -32'sd1, 4'h5), 1'b0, none);
		add_row(mk_in(CMD_INSERT, 32'sd1, 4'hA), 1'b0, none);
		add_row(mk_in(CMD_INSERT, 32'sh5555_5555, 4'h3), 1'b0, none);
		add_row(mk_in(CMD_INSERT, 32'shAAAA_AAAA, 4'hC), 1'b0, none);
		add_row(mk_in(CMD_INSERT, KEY_MIN, 4'h0), 1'b0, none);
		add_row(mk_in(CMD_INSERT, 32'sd100, 4'h7), 1'b0, none);
		add_row(mk_in(CMD_INSERT, -32'sd100, 4'h8), 1'b0, none);
		add_row(mk_in(CMD_INSERT, 32'sd7, 4'h1), 1'b0, none);
		add_row(mk_in(CMD_INSERT, 32'sd7, 4'h2), 1'b0, none);
		add_row(mk_in(CMD_INSERT, 32'sh7FFF_0000, 4'h4), 1'b0, none);
		add_row(mk_in(CMD_INSERT, 32'sh8000_0001, 4'h6), 1'b0, none);
		add_row(mk_in(CMD_INSERT, 32'sd42, 4'h9), 1'b0, none);
		add_row(mk_in(CMD_INSERT, -32'sd42, 4'hB), 1'b0, none);
		add_row(mk_in(CMD_INSERT, 32'sd3, 4'hD), 1'b0, none);
		add_row(mk_in(CMD_INSERT, 32'sd5, 4'hE), 1'b1,
			mk_out(KEY_MAX, KEY_MIN, 5'd16, ST_FULL));
		add_row(mk_in(CMD_DECREASE, KEY_MIN, 4'h0), 1'b1,
			mk_out(KEY_MAX, KEY_MIN, 5'd16, ST_OK));
		add_row(mk_in(CMD_DECREASE, KEY_MAX, 4'hF), 1'b0, none);
		add_row(mk_in(CMD_DECREASE, -32'sd5000, 4'h9), 1'b0, none);
		add_row(mk_in(CMD_DELETE, 32'sd0, 4'hF), 1'b0, none);
		add_row(mk_in(CMD_EXTRACT, KEY_MAX, 4'h0), 1'b0, none);
		add_row(mk_in(CMD_DECREASE, 32'sd0, 4'hF), 1'b0, none);
		add_row(mk_in(CMD_DELETE, KEY_MIN, 4'hE), 1'b0, none);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			@(negedge clk);
			drive_item(dir_rows[i].stim, 0, dir_rows[i].typed, dir_rows[i].want);
		end
		wait_idle();

		for (ph = 0; ph < 4; ph++) begin
			pct = (ph == 1 || ph == 3) ? 69 : (ph == 2) ? 12 : 0;
			for (n = 0; n < RAND_PER_PHASE; n++) begin
				@(negedge clk);
				it = gen_command();
				drive_item(it, pct, 1'b0, none);
			end
			wait_idle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
